// ----- hw/rtl/rcoc_pkg.sv -----
package rcoc_pkg;

  // Field widths.
  localparam int COORD_BITS   = 24;
  localparam int SIDE_BITS    = 16;
  localparam int STATE_BITS   = 2;
  localparam int CROSS_BITS   = 4;
  localparam int CFG_IDX_BITS = 2;

  // Internal geometry works on doubled coordinates, so corners at centre +- side/2 are exact.
  localparam int PT_BITS   = ((COORD_BITS + 1 > SIDE_BITS + 1) ? COORD_BITS + 1 : SIDE_BITS + 1)
                             + 1;
  localparam int DIFF_BITS = PT_BITS + 1;
  localparam int PROD_BITS = 2 * DIFF_BITS;
  localparam int DET_BITS  = PROD_BITS + 1;

  localparam int N_PTS   = 3;
  localparam int N_EDGES = 2;
  localparam int N_SIDES = 4;
  localparam int N_CORN  = 4;
  localparam int N_LANES = 12;

  // Point indices: origin, end A, end B.
  localparam int P_O = 0;
  localparam int P_A = 1;
  localparam int P_B = 2;

  // Multiplier lanes beyond the edge-versus-corner lanes (edge e, corner k at e*4+k).
  localparam int LN_OAB = 8;
  localparam int LN_OAC = 9;
  localparam int LN_ABC = 10;
  localparam int LN_BOC = 11;

  // Corners: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right.
  // Sides: 0 top, 1 bottom, 2 left, 3 right, each as a corner pair.
  localparam int SIDE_Q1 [N_SIDES] = '{0, 2, 0, 1};
  localparam int SIDE_Q2 [N_SIDES] = '{1, 3, 2, 3};

  localparam logic [STATE_BITS-1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [STATE_BITS-1:0] ST_FREE     = 2'd1;
  localparam logic [STATE_BITS-1:0] ST_OCCUPIED = 2'd2;

  localparam logic KIND_LASER = 1'b0;
  localparam logic KIND_SONAR = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;

  typedef logic signed [PT_BITS-1:0]   rcoc_pt_t;
  typedef logic signed [DIFF_BITS-1:0] rcoc_diff_t;
  typedef logic signed [PROD_BITS-1:0] rcoc_prod_t;
  typedef logic signed [DET_BITS-1:0]  rcoc_det_t;

  typedef struct packed {
    logic                  kind;
    logic                  reading_valid;
    logic [COORD_BITS-1:0] end_a_x;
    logic [COORD_BITS-1:0] end_a_y;
    logic [COORD_BITS-1:0] end_b_x;
    logic [COORD_BITS-1:0] end_b_y;
    logic [COORD_BITS-1:0] cell_centre_x;
    logic [COORD_BITS-1:0] cell_centre_y;
    logic [SIDE_BITS-1:0]  cell_side;
    logic [STATE_BITS-1:0] cell_state;
  } rcoc_in_t;

  typedef struct packed {
    logic [STATE_BITS-1:0] new_state;
    logic [CROSS_BITS-1:0] side_crossings;
    logic                  state_changed;
  } rcoc_out_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } rcoc_orient_t;

  // Operands of one orientation test: (a*b) - (c*d).
  typedef struct packed {
    logic [DIFF_BITS-1:0] a;
    logic [DIFF_BITS-1:0] b;
    logic [DIFF_BITS-1:0] c;
    logic [DIFF_BITS-1:0] d;
  } rcoc_lane_t;

  // Everything of an item that bypasses the multipliers.
  typedef struct packed {
    logic                                    valid;
    logic                                    kind;
    logic [STATE_BITS-1:0]                   cur;
    logic                                    cell_hit;
    rcoc_orient_t [N_SIDES-1:0][N_PTS-1:0]   ax;
    logic [N_EDGES-1:0][N_CORN-1:0]          cbox;
    logic [N_SIDES-1:0][N_PTS-1:0]           sbox;
    logic [2:0]                              cone_box;
  } rcoc_flags_t;

  function automatic rcoc_pt_t dbl(input logic [COORD_BITS-1:0] v);
    dbl = {{(PT_BITS - COORD_BITS - 1){v[COORD_BITS-1]}}, v, 1'b0};
  endfunction

  function automatic rcoc_diff_t diff(input rcoc_pt_t a, input rcoc_pt_t b);
    diff = {a[PT_BITS-1], a} - {b[PT_BITS-1], b};
  endfunction

  // Point q inside the bounding box of segment p-r, borders included.
  function automatic logic in_box(input rcoc_pt_t px, input rcoc_pt_t py,
                                  input rcoc_pt_t qx, input rcoc_pt_t qy,
                                  input rcoc_pt_t rx, input rcoc_pt_t ry);
    logic okx, oky;
    okx = (qx >= px && qx <= rx) || (qx >= rx && qx <= px);
    oky = (qy >= py && qy <= ry) || (qy >= ry && qy <= py);
    in_box = okx && oky;
  endfunction

  // Orientation of (p1, p2, q) as operand lane.
  function automatic rcoc_lane_t lane_ops(input rcoc_pt_t p1x, input rcoc_pt_t p1y,
                                          input rcoc_pt_t p2x, input rcoc_pt_t p2y,
                                          input rcoc_pt_t qx, input rcoc_pt_t qy);
    rcoc_lane_t l;
    l.a = diff(p2y, p1y);
    l.b = diff(qx, p2x);
    l.c = diff(p2x, p1x);
    l.d = diff(qy, p2y);
    lane_ops = l;
  endfunction

  function automatic rcoc_orient_t det_sign(input rcoc_det_t d);
    rcoc_orient_t o;
    o.neg  = d[DET_BITS-1];
    o.zero = (d == '0);
    det_sign = o;
  endfunction

  // Orientation against an axis-aligned cell side is -(2*side)*d, so only signs matter.
  function automatic rcoc_orient_t axis_orient(input logic side_nz, input rcoc_diff_t d);
    rcoc_orient_t o;
    o.zero = !side_nz || (d == '0);
    o.neg  = side_nz && !d[DIFF_BITS-1] && (d != '0);
    axis_orient = o;
  endfunction

  function automatic logic seg_hit(input rcoc_orient_t o1, input rcoc_orient_t o2,
                                   input rcoc_orient_t o3, input rcoc_orient_t o4,
                                   input logic b1, input logic b2,
                                   input logic b3, input logic b4);
    seg_hit = ((o1 != o2) && (o3 != o4)) || (o1.zero && b1) || (o2.zero && b2) ||
              (o3.zero && b3) || (o4.zero && b4);
  endfunction

  // Cone (triangle origin, A, B) contains the centre, borders included.
  function automatic logic in_cone(input rcoc_orient_t oab, input rcoc_orient_t d1,
                                   input rcoc_orient_t d2, input rcoc_orient_t d3,
                                   input logic [2:0] bx);
    logic any_neg, any_pos;
    any_neg = d1.neg || d2.neg || d3.neg;
    any_pos = (!d1.neg && !d1.zero) || (!d2.neg && !d2.zero) || (!d3.neg && !d3.zero);
    if (oab.zero) begin
      in_cone = (d1.zero && bx[0]) || (d2.zero && bx[1]) || (d3.zero && bx[2]);
    end else begin
      in_cone = !(any_neg && any_pos);
    end
  endfunction

endpackage

// ----- hw/rtl/ray_cell_occupancy_classifier.sv -----
// Result path: an accepted item moves through the input, operand, product and output registers,
// and the output register drives out_valid/out_data.
// Throughput: one item per clock; busy stays low after reset, so start may be held high.
// The pipeline depth is set by the orientation multipliers, which get a stage of their own.
// Reset (rst_n low, synchronous) empties the pipeline, holds busy high while applied and
// clears both origin registers to zero. The receiver cannot stall the result strobe.
module ray_cell_occupancy_classifier (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  rcoc_pkg::rcoc_in_t                 in_data,
  output logic                               out_valid,
  output rcoc_pkg::rcoc_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcoc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rcoc_pkg::COORD_BITS-1:0]    cfg_data
);
  import rcoc_pkg::*;

  // Configuration: the sensor origin. Writes are always taken; indexes past the
  // register list are dropped.
  logic [COORD_BITS-1:0] origin_x_r;
  logic [COORD_BITS-1:0] origin_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_data;
        CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Busy is only raised while coming out of reset; otherwise a beat is taken in every cycle that start is high.
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Stage 0: input register.
  logic     v1_r;
  rcoc_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  // Stage 1: doubled points, cell corners, comparisons against the axis-aligned sides
  // and the operand differences for every general orientation test.
  rcoc_pt_t    px [N_PTS];
  rcoc_pt_t    py [N_PTS];
  rcoc_pt_t    crx [N_CORN];
  rcoc_pt_t    cry [N_CORN];
  rcoc_pt_t    cx, cy, sd, left, right, top, bot;
  rcoc_diff_t  side_d;
  rcoc_lane_t  lane_nxt [N_LANES];
  rcoc_flags_t fl1_nxt;

  always_comb begin
    px[P_O] = dbl(origin_x_r);
    py[P_O] = dbl(origin_y_r);
    px[P_A] = dbl(in_r.end_a_x);
    py[P_A] = dbl(in_r.end_a_y);
    px[P_B] = dbl(in_r.end_b_x);
    py[P_B] = dbl(in_r.end_b_y);
    cx      = dbl(in_r.cell_centre_x);
    cy      = dbl(in_r.cell_centre_y);
    sd      = {{(PT_BITS - SIDE_BITS){1'b0}}, in_r.cell_side};
    left    = cx - sd;
    right   = cx + sd;
    top     = cy + sd;
    bot     = cy - sd;
    crx[0] = left;   cry[0] = top;
    crx[1] = right;  cry[1] = top;
    crx[2] = left;   cry[2] = bot;
    crx[3] = right;  cry[3] = bot;
    side_d = '0;

    fl1_nxt.valid    = in_r.reading_valid;
    fl1_nxt.kind     = in_r.kind;
    fl1_nxt.cur      = (in_r.cell_state == ST_UNKNOWN || in_r.cell_state == ST_FREE) ?
                       in_r.cell_state : ST_OCCUPIED;
    fl1_nxt.cell_hit = px[P_A] >= left && px[P_A] <= right &&
                       py[P_A] >= bot && py[P_A] <= top;

    for (int s = 0; s < N_SIDES; s++) begin
      for (int p = 0; p < N_PTS; p++) begin
        case (s)
          0:       side_d = diff(py[p], top);
          1:       side_d = diff(py[p], bot);
          2:       side_d = diff(px[p], left);
          default: side_d = diff(px[p], right);
        endcase
        fl1_nxt.ax[s][p]   = axis_orient(in_r.cell_side != '0, side_d);
        fl1_nxt.sbox[s][p] = in_box(crx[SIDE_Q1[s]], cry[SIDE_Q1[s]], px[p], py[p],
                                    crx[SIDE_Q2[s]], cry[SIDE_Q2[s]]);
      end
    end

    for (int e = 0; e < N_EDGES; e++) begin
      for (int k = 0; k < N_CORN; k++) begin
        fl1_nxt.cbox[e][k] = in_box(px[P_O], py[P_O], crx[k], cry[k], px[e+1], py[e+1]);
        lane_nxt[e*N_CORN+k] = lane_ops(px[P_O], py[P_O], px[e+1], py[e+1], crx[k], cry[k]);
      end
    end

    lane_nxt[LN_OAB] = lane_ops(px[P_O], py[P_O], px[P_A], py[P_A], px[P_B], py[P_B]);
    lane_nxt[LN_OAC] = lane_ops(px[P_O], py[P_O], px[P_A], py[P_A], cx, cy);
    lane_nxt[LN_ABC] = lane_ops(px[P_A], py[P_A], px[P_B], py[P_B], cx, cy);
    lane_nxt[LN_BOC] = lane_ops(px[P_B], py[P_B], px[P_O], py[P_O], cx, cy);

    fl1_nxt.cone_box[0] = in_box(px[P_O], py[P_O], cx, cy, px[P_A], py[P_A]);
    fl1_nxt.cone_box[1] = in_box(px[P_A], py[P_A], cx, cy, px[P_B], py[P_B]);
    fl1_nxt.cone_box[2] = in_box(px[P_O], py[P_O], cx, cy, px[P_B], py[P_B]);
  end

  logic        v2_r;
  rcoc_lane_t  lane_r [N_LANES];
  rcoc_flags_t fl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    fl2_r  <= fl1_nxt;
  end

  // Stage 2: one pair of signed multipliers per orientation lane.
  rcoc_prod_t  prod_p_nxt [N_LANES];
  rcoc_prod_t  prod_q_nxt [N_LANES];

  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      prod_p_nxt[i] = $signed(lane_r[i].a) * $signed(lane_r[i].b);
      prod_q_nxt[i] = $signed(lane_r[i].c) * $signed(lane_r[i].d);
    end
  end

  logic        v3_r;
  rcoc_prod_t  prod_p_r [N_LANES];
  rcoc_prod_t  prod_q_r [N_LANES];
  rcoc_flags_t fl3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_p_r <= prod_p_nxt;
    prod_q_r <= prod_q_nxt;
    fl3_r    <= fl2_r;
  end

  // Stage 3: signs of the cross products, side hits per edge, and the state decision.
  // For a valid reading, an unknown cell becomes occupied when the laser end lies in the cell, the
  // sonar cone holds the centre, or exactly one side is crossed; any other crossing makes it free.
  rcoc_orient_t            mo [N_LANES];
  rcoc_det_t               det;
  logic [2:0]              cnt [N_EDGES];
  logic                    hit;
  logic                    hint;
  logic [CROSS_BITS-1:0]   cross_sum;
  rcoc_out_t               out_nxt;

  always_comb begin
    for (int i = 0; i < N_LANES; i++) begin
      det   = {prod_p_r[i][PROD_BITS-1], prod_p_r[i]} - {prod_q_r[i][PROD_BITS-1], prod_q_r[i]};
      mo[i] = det_sign(det);
    end

    hit = 1'b0;
    for (int e = 0; e < N_EDGES; e++) begin
      cnt[e] = '0;
      for (int s = 0; s < N_SIDES; s++) begin
        hit = seg_hit(mo[e*N_CORN+SIDE_Q1[s]], mo[e*N_CORN+SIDE_Q2[s]],
                      fl3_r.ax[s][P_O], fl3_r.ax[s][e+1],
                      fl3_r.cbox[e][SIDE_Q1[s]], fl3_r.cbox[e][SIDE_Q2[s]],
                      fl3_r.sbox[s][P_O], fl3_r.sbox[s][e+1]);
        cnt[e] = cnt[e] + {2'b00, hit};
      end
    end

    if (fl3_r.kind == KIND_LASER) begin
      cross_sum = {1'b0, cnt[0]};
      hint      = fl3_r.cell_hit;
    end else begin
      cross_sum = {1'b0, cnt[0]} + {1'b0, cnt[1]};
      hint      = in_cone(mo[LN_OAB], mo[LN_OAC], mo[LN_ABC], mo[LN_BOC], fl3_r.cone_box);
    end

    out_nxt.new_state      = fl3_r.cur;
    out_nxt.side_crossings = '0;
    if (fl3_r.valid) begin
      out_nxt.side_crossings = cross_sum;
      if (fl3_r.cur == ST_UNKNOWN) begin
        if (hint || cross_sum == CROSS_BITS'(1)) begin
          out_nxt.new_state = ST_OCCUPIED;
        end else if (cross_sum != '0) begin
          out_nxt.new_state = ST_FREE;
        end
      end
    end
    out_nxt.state_changed = (out_nxt.new_state != fl3_r.cur);
  end

  logic      out_valid_r;
  rcoc_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every result beat comes from an accepted item.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start && !busy_r, 4))
    else $error("result beat without a matching accepted item");

  // At most four sides per ray segment, and two segments at most.
  a_cross_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.side_crossings <= CROSS_BITS'(8))
    else $error("side crossing count out of range");

  // A change only ever moves an unknown cell to a known state.
  a_change_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.state_changed |->
      out_r.new_state != ST_UNKNOWN && $past(fl3_r.cur) == ST_UNKNOWN)
    else $error("state change on a cell that was not unknown");

  // An out-of-range reading leaves the cell alone and counts nothing.
  a_invalid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(fl3_r.valid) |->
      out_r.side_crossings == '0 && !out_r.state_changed)
    else $error("invalid reading produced crossings or a state change");

endmodule
